// ----- rtl/unsigned_radix_formatter_assert.svh -----
// ----------------------------------------------------------------------------
// unsigned radix formatter assertion macros
// Property wrappers used by the formatter; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_RADIX_FORMATTER_ASSERT_SVH
`define UNSIGNED_RADIX_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define URF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("unsigned_radix_formatter: same-cycle check failed");
// next-cycle implication
`define URF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("unsigned_radix_formatter: next-cycle check failed");
`else
`define URF_ASSERT_IMPLY(label, ante, cons)
`define URF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/urf_pkg.sv -----
// ----------------------------------------------------------------------------
// urf_pkg
// Codes, character constants and digit lookup for the radix formatter.
// ----------------------------------------------------------------------------
package urf_pkg;

   // length modifier codes
   localparam logic [1:0] LEN_DEFAULT = 2'd0;
   localparam logic [1:0] LEN_SHORT   = 2'd1;
   localparam logic [1:0] LEN_LONG    = 2'd2;

   // radix codes (unused code acts as decimal)
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   // ascii characters
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [7:0] CHAR_X_UPPER = 8'h58;

   localparam int PREC_W = 6;

   // digit tables
   localparam logic [7:0] HEX_LOWER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };
   localparam logic [7:0] HEX_UPPER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // one digit to its ascii character
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      return upper ? HEX_UPPER[digit] : HEX_LOWER[digit];
   endfunction

endpackage

// ----- rtl/urf_bcd.sv -----
// ----------------------------------------------------------------------------
// urf_bcd
// Bit-serial binary to bcd converter (shift and add 3), one bit per cycle.
// ----------------------------------------------------------------------------
module urf_bcd #(
   parameter int VALUE_WIDTH = 64,
   parameter int BCD_DIGITS  = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_WIDTH-1:0]    bin_value,
   output logic                      done,
   output logic [4*BCD_DIGITS-1:0]   bcd_value
);

   localparam int BCD_W = 4 * BCD_DIGITS;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [BCD_W-1:0]       bcd_ff;
   logic [BCD_W-1:0]       adj;
   logic [BCD_W-1:0]       bcd_in;

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                   : bcd_ff[4*i +: 4];
      end
      bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
   end

   // conversion sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(VALUE_WIDTH);
            bin_ff  <= bin_value;
            bcd_ff  <= '0;
         end else if (busy_ff) begin
            bcd_ff <= bcd_in;
            bin_ff <= bin_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign bcd_value = bcd_ff;

endmodule

// ----- rtl/urf_buf.sv -----
// ----------------------------------------------------------------------------
// urf_buf
// Character buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module urf_buf #(
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/unsigned_radix_formatter.sv -----
// ----------------------------------------------------------------------------
// unsigned_radix_formatter
// Formats one unsigned value as decimal, octal or hex ascii text.
// ----------------------------------------------------------------------------
// One request at a time. Decimal values (nonzero) first pass through the
// bit-serial bcd converter; octal and hex skip it. The text is then built
// least significant character first into the character buffer at one
// character per cycle (digits, a step to find the end, octal zero, precision
// zeros, prefix), and read back most significant first at one character per
// cycle while the result side takes them. The request side is stalled from
// acceptance until the last character has been read from the buffer; the
// final character may still sit in the output register when the next
// request is taken.
module unsigned_radix_formatter #(
   parameter int MAX_CHARS   = 64,
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_length_mod,
   input  logic [1:0]  req_radix_select,
   input  logic        req_upper_case,
   input  logic        req_precision_given,
   input  logic [5:0]  req_precision,
   input  logic        req_alt_form,
   input  logic        req_zero_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int WORK_W     = 4 * BCD_DIGITS;
   localparam int CNT_W      = $clog2(MAX_CHARS + 1);
   localparam int ADDR_W     = $clog2(MAX_CHARS);
   localparam int CMP_W      = (CNT_W > urf_pkg::PREC_W) ? CNT_W : urf_pkg::PREC_W;
   localparam int PREC_LIMIT = ((MAX_CHARS - 2) < 62) ? (MAX_CHARS - 2) : 62;
   localparam logic [urf_pkg::PREC_W-1:0] PREC_MAX = urf_pkg::PREC_W'(PREC_LIMIT);
   localparam logic [CNT_W-1:0]           MAX_CNT  = CNT_W'(MAX_CHARS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_BCD, ST_DIGITS, ST_ALTZ, ST_PAD, ST_PFX_X, ST_PFX_0, ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [WORK_W-1:0]           work_ff, work_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [urf_pkg::PREC_W-1:0]  pad_ff, pad_in;
   logic                        alt_oct_ff, alt_oct_in;
   logic                        prefix_ff, prefix_in;
   logic                        upper_ff, upper_in;
   logic                        oct_ff, oct_in;
   logic                        pend_ff, pend_in;
   logic                        pend_last_ff, pend_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0]      trunc;
   logic                        is_zero;
   logic                        is_oct;
   logic                        is_hex;
   logic [urf_pkg::PREC_W-1:0]  prec_eff;
   logic                        wr_req;
   logic                        wr_en;
   logic [7:0]                  wr_data;
   logic                        room;
   logic                        bcd_start;
   logic                        bcd_done;
   logic [WORK_W-1:0]           bcd_value;
   logic                        issue;
   logic                        load_out;
   logic [7:0]                  rd_data;
   logic [3:0]                  digit;

   // length truncation and request decode
   always_comb begin
      case (req_length_mod)
         urf_pkg::LEN_SHORT: trunc = VALUE_WIDTH'(req_value[15:0]);
         urf_pkg::LEN_LONG:  trunc = req_value[VALUE_WIDTH-1:0];
         default:            trunc = VALUE_WIDTH'(req_value[31:0]);
      endcase
      is_zero = (trunc == '0);
      is_oct  = (req_radix_select == urf_pkg::RADIX_OCT);
      is_hex  = (req_radix_select == urf_pkg::RADIX_HEX);
      if (!req_precision_given) begin
         prec_eff = '0;
      end else if (req_precision > PREC_MAX) begin
         prec_eff = PREC_MAX;
      end else begin
         prec_eff = req_precision;
      end
   end

   assign room  = (n_ff < MAX_CNT);
   assign digit = oct_ff ? {1'b0, work_ff[2:0]} : work_ff[3:0];

   // sequencer and output register next values
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      pad_in       = pad_ff;
      alt_oct_in   = alt_oct_ff;
      prefix_in    = prefix_ff;
      upper_in     = upper_ff;
      oct_in       = oct_ff;
      wr_req       = 1'b0;
      wr_data      = urf_pkg::CHAR_ZERO;
      bcd_start    = 1'b0;
      n_in         = n_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in       = '0;
               upper_in   = req_upper_case && is_hex;
               oct_in     = is_oct;
               alt_oct_in = !is_zero && req_alt_form && is_oct;
               prefix_in  = !is_zero && req_alt_form && is_hex &&
                            !(req_zero_flag && !req_precision_given);
               if (!is_zero) begin
                  pad_in = prec_eff;
               end else if (req_precision_given && req_precision == '0) begin
                  pad_in = (req_alt_form && is_oct) ? urf_pkg::PREC_W'(1) : '0;
               end else if (prec_eff == '0) begin
                  pad_in = urf_pkg::PREC_W'(1);
               end else begin
                  pad_in = prec_eff;
               end
               if (!is_zero && !is_oct && !is_hex) begin
                  bcd_start = 1'b1;
                  state_in  = ST_BCD;
               end else begin
                  work_in  = WORK_W'(trunc);
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_BCD: begin
            if (bcd_done) begin
               work_in  = bcd_value;
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (work_ff != '0) begin
               wr_req  = 1'b1;
               wr_data = urf_pkg::digit_char(digit, upper_ff);
               work_in = oct_ff ? (work_ff >> 3) : (work_ff >> 4);
            end else begin
               state_in = alt_oct_ff ? ST_ALTZ : ST_PAD;
            end
         end
         ST_ALTZ: begin
            wr_req   = 1'b1;
            state_in = ST_PAD;
         end
         ST_PAD: begin
            if (CMP_W'(n_ff) < CMP_W'(pad_ff)) begin
               wr_req = 1'b1;
            end else if (prefix_ff) begin
               state_in = ST_PFX_X;
            end else begin
               rem_in   = n_ff;
               state_in = ST_EMIT;
            end
         end
         ST_PFX_X: begin
            wr_req   = 1'b1;
            wr_data  = upper_ff ? urf_pkg::CHAR_X_UPPER : urf_pkg::CHAR_X_LOWER;
            state_in = ST_PFX_0;
         end
         ST_PFX_0: begin
            wr_req    = 1'b1;
            prefix_in = 1'b0;
            state_in  = ST_PAD;
         end
         ST_EMIT: begin
            if (rem_ff == '0 && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // buffer write, dropped once the buffer is full
      wr_en = wr_req && room;
      if (wr_en) begin
         n_in = n_ff + 1'b1;
      end

      // read back most significant first through a one-entry pending slot
      load_out     = pend_ff && (!rsp_valid_ff || !rsp_stall);
      issue        = (state_ff == ST_EMIT) && (rem_ff != '0) && (!pend_ff || load_out);
      pend_in      = issue ? 1'b1 : (load_out ? 1'b0 : pend_ff);
      pend_last_in = issue ? (rem_ff == CNT_W'(1)) : pend_last_ff;
      if (issue) begin
         rem_in = rem_ff - 1'b1;
      end

      // output register
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rd_data;
         rsp_last_in  = pend_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff      <= work_in;
      pad_ff       <= pad_in;
      alt_oct_ff   <= alt_oct_in;
      prefix_ff    <= prefix_in;
      upper_ff     <= upper_in;
      oct_ff       <= oct_in;
      pend_last_ff <= pend_last_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // decimal converter
   urf_bcd #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .BCD_DIGITS  (BCD_DIGITS)
   ) u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (bcd_start),
      .bin_value (trunc),
      .done      (bcd_done),
      .bcd_value (bcd_value)
   );

   // character buffer
   urf_buf #(
      .DEPTH (MAX_CHARS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (ADDR_W'(rem_ff - 1'b1)),
      .rd_data (rd_data)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
`include "unsigned_radix_formatter_assert.svh"
   `URF_ASSERT_IMPLY(a_idle_drained, !req_stall, rem_ff == '0 && !pend_ff)
   `URF_ASSERT_NEXT(a_pending_kept, pend_ff && rsp_valid_ff && rsp_stall, pend_ff)
   `URF_ASSERT_IMPLY(a_read_bound, 1'b1, rem_ff <= n_ff && n_ff <= MAX_CNT)

endmodule
